// File: design/cube_map_face_select_core_assert.svh
// Assertion macros for the cube map face select core.
// Used by the top level only; needs no package.
`ifndef CUBE_MAP_FACE_SELECT_CORE_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMFS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication with a fixed delay, disabled during reset.
`define CMFS_ASSERT_DLY(lbl, clk, rst, ante, n, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error(msg);

`endif

// File: design/cmfs_pkg.sv
// Shared constants, face codes and the divider beat type of the
// cube map face select core. No dependencies.
`timescale 1ns / 1ps

package cmfs_pkg;

   // Field widths
   localparam int DIR_BITS  = 16;
   localparam int UV_BITS   = 16;
   localparam int FACE_BITS = 3;

   // Remainder / divisor width and quotient width of the divider
   localparam int RW        = DIR_BITS + 1;
   localparam int QW        = UV_BITS + 1;
   localparam int DIV_STEPS = QW;

   // Accept edge to result strobe, in clock cycles
   localparam int PIPE_LATENCY = DIV_STEPS + 4;

   // Face codes
   localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

   // Coordinate constants
   localparam logic [UV_BITS-1:0] UV_HALF = {1'b1, {(UV_BITS-1){1'b0}}};
   localparam logic [UV_BITS-1:0] UV_MAX  = {UV_BITS{1'b1}};

   // One beat traveling through the divider stages (both lanes)
   typedef struct packed {
      logic                 valid;
      logic [FACE_BITS-1:0] face;
      logic                 degenerate;
      logic [RW-1:0]        divisor;
      logic [RW-1:0]        rem_u;
      logic [RW-1:0]        rem_v;
      logic [QW-1:0]        quo_u;
      logic [QW-1:0]        quo_v;
      logic                 sat_u;
      logic                 sat_v;
   } div_beat_type;

endpackage

// File: design/cmfs_select.sv
// Front end: input register, major axis / face selection, and divider setup.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps

module cmfs_select (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic signed [cmfs_pkg::DIR_BITS-1:0] dir_x,
   input  logic signed [cmfs_pkg::DIR_BITS-1:0] dir_y,
   input  logic signed [cmfs_pkg::DIR_BITS-1:0] dir_z,
   output cmfs_pkg::div_beat_type           beat_out
);

   localparam int W = cmfs_pkg::DIR_BITS;

   // Stage 1: input register
   logic                in_valid_ff;
   logic signed [W-1:0] x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= dir_x;
         y_ff <= dir_y;
         z_ff <= dir_z;
      end
   end

   // Stage 2 logic: magnitudes, major axis, minor operands
   logic signed [W:0] xe, ye, ze, xn, yn, zn;
   logic [W-1:0]      ax, ay, az;
   logic [W-1:0]      m_in;
   logic signed [W:0] a_in, b_in;
   logic [cmfs_pkg::FACE_BITS-1:0] face_in;
   logic              degen_in;

   assign xe = {x_ff[W-1], x_ff};
   assign ye = {y_ff[W-1], y_ff};
   assign ze = {z_ff[W-1], z_ff};
   assign xn = -xe;
   assign yn = -ye;
   assign zn = -ze;
   assign ax = x_ff[W-1] ? xn[W-1:0] : x_ff[W-1:0];
   assign ay = y_ff[W-1] ? yn[W-1:0] : y_ff[W-1:0];
   assign az = z_ff[W-1] ? zn[W-1:0] : z_ff[W-1:0];
   assign degen_in = (x_ff == '0) && (y_ff == '0) && (z_ff == '0);

   always_comb begin
      if ((ax > ay) && (ax > az)) begin
         m_in = ax;
         b_in = ye;
         if (!x_ff[W-1]) begin
            face_in = cmfs_pkg::FACE_POS_X;
            a_in    = ze;
         end else begin
            face_in = cmfs_pkg::FACE_NEG_X;
            a_in    = zn;
         end
      end else if (ay > az) begin
         m_in = ay;
         a_in = xe;
         if (!y_ff[W-1]) begin
            face_in = cmfs_pkg::FACE_POS_Y;
            b_in    = ze;
         end else begin
            face_in = cmfs_pkg::FACE_NEG_Y;
            b_in    = zn;
         end
      end else begin
         m_in = az;
         b_in = ye;
         if (!z_ff[W-1] && !degen_in) begin
            face_in = cmfs_pkg::FACE_POS_Z;
            a_in    = xn;
         end else begin
            // negative z, and the all-zero vector
            face_in = cmfs_pkg::FACE_NEG_Z;
            a_in    = xe;
         end
      end
   end

   // Stage 2 register
   logic                           sel_valid_ff;
   logic [cmfs_pkg::FACE_BITS-1:0] face_ff;
   logic                           degen_ff;
   logic [W-1:0]                   m_ff;
   logic [W:0]                     a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      face_ff  <= face_in;
      degen_ff <= degen_in;
      m_ff     <= m_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
   end

   // Stage 3 logic: shift minor into [0, 2m], flag the top end
   logic [W+1:0]             sum_u, sum_v;
   logic [cmfs_pkg::RW-1:0]  two_m;
   cmfs_pkg::div_beat_type   beat_in;

   assign sum_u = {a_ff[W], a_ff} + {2'b00, m_ff};
   assign sum_v = {b_ff[W], b_ff} + {2'b00, m_ff};
   assign two_m = {m_ff, 1'b0};

   always_comb begin
      beat_in.valid      = sel_valid_ff;
      beat_in.face       = face_ff;
      beat_in.degenerate = degen_ff;
      beat_in.divisor    = {1'b0, m_ff};
      beat_in.rem_u      = sum_u[W:0];
      beat_in.rem_v      = sum_v[W:0];
      beat_in.quo_u      = '0;
      beat_in.quo_v      = '0;
      beat_in.sat_u      = (sum_u[W:0] == two_m);
      beat_in.sat_v      = (sum_v[W:0] == two_m);
   end

   // Stage 3 register
   logic                   setup_valid_ff;
   cmfs_pkg::div_beat_type setup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
      end else begin
         setup_valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      setup_ff <= beat_in;
   end

   always_comb begin
      beat_out       = setup_ff;
      beat_out.valid = setup_valid_ff;
   end

endmodule

// File: design/cmfs_div_step.sv
// One restoring division step for both coordinate lanes, registered.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps

module cmfs_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  cmfs_pkg::div_beat_type beat_in,
   output cmfs_pkg::div_beat_type beat_out
);

   localparam int RW = cmfs_pkg::RW;
   localparam int QW = cmfs_pkg::QW;

   // Compare, subtract, then shift the remainder for the next bit
   logic          ge_u, ge_v;
   logic [RW-1:0] r_u, r_v;
   cmfs_pkg::div_beat_type beat_nx;

   assign ge_u = beat_in.rem_u >= beat_in.divisor;
   assign ge_v = beat_in.rem_v >= beat_in.divisor;
   assign r_u  = ge_u ? (beat_in.rem_u - beat_in.divisor) : beat_in.rem_u;
   assign r_v  = ge_v ? (beat_in.rem_v - beat_in.divisor) : beat_in.rem_v;

   always_comb begin
      beat_nx       = beat_in;
      beat_nx.rem_u = {r_u[RW-2:0], 1'b0};
      beat_nx.rem_v = {r_v[RW-2:0], 1'b0};
      beat_nx.quo_u = {beat_in.quo_u[QW-2:0], ge_u};
      beat_nx.quo_v = {beat_in.quo_v[QW-2:0], ge_v};
   end

   // Step register
   logic                   valid_ff;
   cmfs_pkg::div_beat_type beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_nx;
   end

   always_comb begin
      beat_out       = beat_ff;
      beat_out.valid = valid_ff;
   end

endmodule

// File: design/cmfs_round.sv
// Output stage: round half up, saturate, degenerate override, result registers.
// Depends on cmfs_pkg.
`timescale 1ns / 1ps

module cmfs_round (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmfs_pkg::div_beat_type               beat_in,
   output logic                                 rsp_valid,
   output logic [cmfs_pkg::FACE_BITS-1:0]       rsp_face,
   output logic [cmfs_pkg::UV_BITS-1:0]         rsp_coord_u,
   output logic [cmfs_pkg::UV_BITS-1:0]         rsp_coord_v,
   output logic                                 rsp_degenerate
);

   localparam int QW = cmfs_pkg::QW;
   localparam int UV = cmfs_pkg::UV_BITS;

   // Quotient holds floor(sum * 2^UV / m); (q + 1) / 2 rounds half up
   logic [QW:0]   inc_u, inc_v;
   logic [UV-1:0] u_in, v_in;

   assign inc_u = {1'b0, beat_in.quo_u} + {{QW{1'b0}}, 1'b1};
   assign inc_v = {1'b0, beat_in.quo_v} + {{QW{1'b0}}, 1'b1};

   always_comb begin
      if (beat_in.degenerate) begin
         u_in = cmfs_pkg::UV_HALF;
         v_in = cmfs_pkg::UV_HALF;
      end else begin
         u_in = (beat_in.sat_u || inc_u[QW]) ? cmfs_pkg::UV_MAX : inc_u[UV:1];
         v_in = (beat_in.sat_v || inc_v[QW]) ? cmfs_pkg::UV_MAX : inc_v[UV:1];
      end
   end

   // Result registers
   logic                           valid_ff;
   logic [cmfs_pkg::FACE_BITS-1:0] face_ff;
   logic [UV-1:0]                  u_ff, v_ff;
   logic                           degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      face_ff  <= beat_in.face;
      u_ff     <= u_in;
      v_ff     <= v_in;
      degen_ff <= beat_in.degenerate;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_face       = face_ff;
   assign rsp_coord_u    = u_ff;
   assign rsp_coord_v    = v_ff;
   assign rsp_degenerate = degen_ff;

endmodule

// File: design/cube_map_face_select_core.sv
// Cube map face select core: top level, ties select, divider chain and output stage.
// Depends on cmfs_pkg, cmfs_select, cmfs_div_step, cmfs_round and the assertion header.
`timescale 1ns / 1ps

// A fully pipelined face selector: one direction beat may enter on every clock
// (busy is high only while reset is asserted). Its result is driven on the
// rsp_ ports, marked by rsp_valid for exactly one cycle, and is taken at the
// clock edge that samples rsp_valid high. The divider chain retires one
// quotient bit per stage for both coordinates at once, behind three front
// stages (input, axis select, setup) and one output stage. Results cannot be
// held off; the sink must take every strobe.

`include "cube_map_face_select_core_assert.svh"

module cube_map_face_select_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [cmfs_pkg::DIR_BITS-1:0] req_dir_x,
   input  logic signed [cmfs_pkg::DIR_BITS-1:0] req_dir_y,
   input  logic signed [cmfs_pkg::DIR_BITS-1:0] req_dir_z,
   output logic                                 rsp_valid,
   output logic [cmfs_pkg::FACE_BITS-1:0]       rsp_face,
   output logic [cmfs_pkg::UV_BITS-1:0]         rsp_coord_u,
   output logic [cmfs_pkg::UV_BITS-1:0]         rsp_coord_v,
   output logic                                 rsp_degenerate
);

   // Input beat handshake
   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // Front end
   cmfs_pkg::div_beat_type chain [cmfs_pkg::DIV_STEPS+1];

   cmfs_select u_select (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .beat_out (chain[0])
   );

   // Divider chain, one quotient bit per stage
   for (genvar i = 0; i < cmfs_pkg::DIV_STEPS; i++) begin : g_div
      cmfs_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (chain[i]),
         .beat_out (chain[i+1])
      );
   end

   // Rounding and result registers
   cmfs_round u_round (
      .clock          (clock),
      .reset          (reset),
      .beat_in        (chain[cmfs_pkg::DIV_STEPS]),
      .rsp_valid      (rsp_valid),
      .rsp_face       (rsp_face),
      .rsp_coord_u    (rsp_coord_u),
      .rsp_coord_v    (rsp_coord_v),
      .rsp_degenerate (rsp_degenerate)
   );

   // Checks
   `CMFS_ASSERT_DLY(a_fixed_latency, clock, reset, accept, cmfs_pkg::PIPE_LATENCY, rsp_valid, "accepted beat did not produce a result on time")
   `CMFS_ASSERT_IMP(a_no_phantom, clock, reset, rsp_valid, $past(accept, cmfs_pkg::PIPE_LATENCY), "result strobe without a matching accepted beat")
   `CMFS_ASSERT_IMP(a_degenerate_out, clock, reset, rsp_valid && rsp_degenerate, (rsp_face == cmfs_pkg::FACE_NEG_Z) && (rsp_coord_u == cmfs_pkg::UV_HALF) && (rsp_coord_v == cmfs_pkg::UV_HALF), "degenerate result has wrong face or coordinates")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the cube map face select core.
// Depends on cmfs_pkg and cube_map_face_select_core; holds its own face/uv predictor.
`timescale 1ns / 1ps

module testbench;
   import cmfs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      logic [FACE_BITS-1:0] face;
      logic [UV_BITS-1:0]   coord_u;
      logic [UV_BITS-1:0]   coord_v;
      logic                 degenerate;
   } face_result_t;

   // Predicts one face/uv beat per accepted direction and checks results in order
   class FaceScoreboard;
      face_result_t expected_q[$];
      int           errors = 0;

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // Map a minor component in [-m, m] onto unsigned Q0.UV_BITS, halves up
      function logic [UV_BITS-1:0] map_coord(longint a, longint m);
         longint sum;
         longint q;
         sum = a + m;
         if (sum < 0) sum = 0;
         q = ((sum << UV_BITS) + m) / (2 * m);
         if (q > longint'(UV_MAX)) return UV_MAX;
         return q[UV_BITS-1:0];
      endfunction

      function face_result_t select_face(longint x, longint y, longint z);
         face_result_t r;
         longint       ax, ay, az, a, b, m;
         ax = (x < 0) ? -x : x;
         ay = (y < 0) ? -y : y;
         az = (z < 0) ? -z : z;
         r.degenerate = 1'b0;
         // All-zero vector goes to the back face at the center
         if (x == 0 && y == 0 && z == 0) begin
            r.face       = FACE_NEG_Z;
            r.coord_u    = UV_HALF;
            r.coord_v    = UV_HALF;
            r.degenerate = 1'b1;
            return r;
         end
         // Ties: x needs strict win over both, then y over z, else z
         if (ax > ay && ax > az) begin
            m = ax;
            if (x > 0) begin r.face = FACE_POS_X; a = z;  b = y; end
            else begin       r.face = FACE_NEG_X; a = -z; b = y; end
         end else if (ay > az) begin
            m = ay;
            if (y > 0) begin r.face = FACE_POS_Y; a = x; b = z;  end
            else begin       r.face = FACE_NEG_Y; a = x; b = -z; end
         end else begin
            m = az;
            if (z > 0) begin r.face = FACE_POS_Z; a = -x; b = y; end
            else begin       r.face = FACE_NEG_Z; a = x;  b = y; end
         end
         r.coord_u = map_coord(a, m);
         r.coord_v = map_coord(b, m);
         return r;
      endfunction

      function void note_input(logic signed [DIR_BITS-1:0] x,
                               logic signed [DIR_BITS-1:0] y,
                               logic signed [DIR_BITS-1:0] z);
         expected_q.push_back(select_face(longint'(x), longint'(y), longint'(z)));
      endfunction

      task check_result(logic [FACE_BITS-1:0] face, logic [UV_BITS-1:0] u,
                        logic [UV_BITS-1:0] v, logic deg);
         face_result_t e;
         if (expected_q.size() == 0) begin
            report($sformatf("result face=%0d u=%0d v=%0d with nothing pending",
                             face, u, v));
            return;
         end
         e = expected_q.pop_front();
         if (face !== e.face)
            report($sformatf("face got %0d want %0d", face, e.face));
         if (u !== e.coord_u)
            report($sformatf("coord_u got %0d want %0d", u, e.coord_u));
         if (v !== e.coord_v)
            report($sformatf("coord_v got %0d want %0d", v, e.coord_v));
         if (deg !== e.degenerate)
            report($sformatf("degenerate got %0b want %0b", deg, e.degenerate));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic signed [DIR_BITS-1:0] req_dir_x = '0;
   logic signed [DIR_BITS-1:0] req_dir_y = '0;
   logic signed [DIR_BITS-1:0] req_dir_z = '0;
   logic                       rsp_valid;
   logic [FACE_BITS-1:0]       rsp_face;
   logic [UV_BITS-1:0]         rsp_coord_u;
   logic [UV_BITS-1:0]         rsp_coord_v;
   logic                       rsp_degenerate;

   FaceScoreboard sb = new();
   int            cycle_count = 0;
   bit            idle_on = 1'b1;

   cube_map_face_select_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .req_dir_z      (req_dir_z),
      .rsp_valid      (rsp_valid),
      .rsp_face       (rsp_face),
      .rsp_coord_u    (rsp_coord_u),
      .rsp_coord_v    (rsp_coord_v),
      .rsp_degenerate (rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Note accepted beats first, then check result strobes, all on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_input(req_dir_x, req_dir_y, req_dir_z);
         if (rsp_valid)
            sb.check_result(rsp_face, rsp_coord_u, rsp_coord_v, rsp_degenerate);
      end
   end

   // Present one direction beat after a random idle gap (when idle_on is set) and hold it until taken
   task drive_dir(int x, int y, int z);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 32) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start     <= 1'b1;
      req_dir_x <= DIR_BITS'(x);
      req_dir_y <= DIR_BITS'(y);
      req_dir_z <= DIR_BITS'(z);
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int x, y, z, m, axis, kind;
      int comp[3];

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero vector, each face, extremes, ties, saturation
      drive_dir(0, 0, 0);
      drive_dir(1, 0, 0);
      drive_dir(-1, 0, 0);
      drive_dir(0, 1, 0);
      drive_dir(0, -1, 0);
      drive_dir(0, 0, 1);
      drive_dir(0, 0, -1);
      drive_dir(32767, 0, 0);
      drive_dir(-32768, 0, 0);
      drive_dir(0, 32767, 0);
      drive_dir(0, -32768, 0);
      drive_dir(0, 0, -32768);
      drive_dir(-32768, -32768, -32768);
      drive_dir(32767, 32767, 32767);
      drive_dir(100, 100, 5);
      drive_dir(5, 100, 100);
      drive_dir(100, -100, 100);
      drive_dir(-32768, 32767, -32767);
      drive_dir(32767, -32768, 32767);
      drive_dir(-100, 3, -100);
      drive_dir(-32768, -32768, 0);
      drive_dir(0, 5, 5);
      drive_dir(7, -3, 2);

      // Random: full range, small values, extremes, ties and near-ties
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_on = !(i >= 200 && i < 300);
         kind = $urandom_range(0, 5);
         case (kind)
            0, 5: begin
               x = $urandom_range(0, 65535);
               y = $urandom_range(0, 65535);
               z = $urandom_range(0, 65535);
            end
            1: begin
               x = int'($urandom_range(0, 8)) - 4;
               y = int'($urandom_range(0, 8)) - 4;
               z = int'($urandom_range(0, 8)) - 4;
            end
            2: begin
               x = $urandom_range(0, 65535);
               y = $urandom_range(0, 65535);
               z = $urandom_range(0, 65535);
               m = $urandom_range(0, 1) ? -32768 : 32767;
               case ($urandom_range(0, 2))
                  0: x = m;
                  1: y = m;
                  default: z = m;
               endcase
            end
            3: begin
               // Equal magnitudes with random signs, some components smaller
               m = $urandom_range(1, 32768);
               for (int k = 0; k < 3; k++) begin
                  comp[k] = $urandom_range(0, 2) ? m : int'($urandom_range(0, m));
                  if ($urandom_range(0, 1)) comp[k] = -comp[k];
               end
               x = comp[0]; y = comp[1]; z = comp[2];
            end
            default: begin
               // Minors at or just below the major magnitude
               axis = $urandom_range(0, 2);
               m = $urandom_range(1, 32767);
               for (int k = 0; k < 3; k++) begin
                  comp[k] = (k == axis) ? m : m - int'($urandom_range(0, 2));
                  if (comp[k] < 0) comp[k] = 0;
                  if ($urandom_range(0, 1)) comp[k] = -comp[k];
               end
               x = comp[0]; y = comp[1]; z = comp[2];
            end
         endcase
         drive_dir(x, y, z);
      end
      start <= 1'b0;

      // Drain, then watch a little longer for stray strobes
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// File: cube_map_face_select_core.f
+incdir+design
design/cmfs_pkg.sv
design/cmfs_select.sv
design/cmfs_div_step.sv
design/cmfs_round.sv
design/cube_map_face_select_core.sv
tb/testbench.sv
